>>> rtl/tsas_pkg.sv
// Shared types, codes and constants of the three-literal CNF assignment search block.
package tsas_pkg;

   // Fixed limits and field widths of the request, response and register port.
   localparam int unsigned VARS_MAX            = 64;
   localparam int unsigned CLAUSES_MAX_DEFAULT = 1024;
   localparam int unsigned ASSIGN_W            = 64;
   localparam int unsigned VAR_W               = 7;
   localparam int unsigned BITPOS_W            = 6;
   localparam int unsigned CLAUSE_W            = 3 * BITPOS_W + 3;
   localparam int unsigned FUNC_W              = 2;
   localparam int unsigned STATUS_W            = 3;
   localparam int unsigned CSR_INDEX_W         = 2;

   // Request function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_FIND  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_SOLUTION  = 3'd0,
      STATUS_EXHAUSTED = 3'd1,
      STATUS_ACCEPTED  = 3'd2,
      STATUS_REJECTED  = 3'd3,
      STATUS_CLEARED   = 3'd4
   } status_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VAR_COUNT   = 2'd0,
      CSR_RANGE_START = 2'd1,
      CSR_RANGE_END   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUND,
      ST_FETCH,
      ST_TEST,
      ST_REPLY
   } state_type;

   // One request item.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [VAR_W-1:0]  var_a;
      logic [VAR_W-1:0]  var_b;
      logic [VAR_W-1:0]  var_c;
      logic              neg_a;
      logic              neg_b;
      logic              neg_c;
   } req_type;

   // One response item.
   typedef struct packed {
      status_type          status;
      logic [ASSIGN_W-1:0] assignment;
   } rsp_type;

   // One literal of a clause while it is being sorted.
   typedef struct packed {
      logic [VAR_W-1:0] idx;
      logic             neg;
   } lit_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan_start;
      logic next_clause;
      logic skip;
      logic found;
      logic exhaust;
      logic send;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_find;
      logic bound_fail;
      logic table_empty;
      logic clause_false;
      logic last_clause;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/tsas_datapath.sv
// Datapath of the assignment search: registers, clause memory, skip arithmetic, output register.
module tsas_datapath
   import tsas_pkg::*;
#(
   parameter int unsigned CLAUSES_MAX = CLAUSES_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ASSIGN_W-1:0]    csr_data,
   input  ctl_cmd_type            cmd,
   output dp_status_type          dp_status
);

   localparam int unsigned IDX_W = (CLAUSES_MAX > 1) ? $clog2(CLAUSES_MAX) : 1;
   localparam int unsigned CNT_W = $clog2(CLAUSES_MAX + 1);

   // Configuration registers.
   logic [VAR_W-1:0]    var_count_ff;
   logic [ASSIGN_W-1:0] range_start_ff;
   logic [ASSIGN_W-1:0] range_end_ff;

   // Search state.
   logic [CNT_W-1:0]    total_ff,  total_in;
   logic [ASSIGN_W-1:0] pos_ff,    pos_in;
   logic                done_ff,   done_in;
   logic [IDX_W-1:0]    idx_ff,    idx_in;

   // Pending result and output register.
   status_type          res_status_ff, res_status_in;
   logic [ASSIGN_W-1:0] res_assign_ff, res_assign_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   // Clause memory.
   logic [CLAUSE_W-1:0] clause_mem [CLAUSES_MAX];
   logic [CLAUSE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [CLAUSE_W-1:0] mem_wdata;

   // Load decoding.
   lit_type             lit_a, lit_b, lit_c;
   lit_type             s1_b, s1_c, s2_a, s2_c, s3_a, s3_b;
   logic                load_ok;
   logic [VAR_W-1:0]    adj_a, adj_b, adj_c;

   // Clause test and arithmetic.
   logic                clause_false;
   logic [ASSIGN_W-1:0] step_mask;
   logic [ASSIGN_W-1:0] skip_base;
   logic [ASSIGN_W:0]   skip_sum;
   logic [ASSIGN_W:0]   incr_sum;
   logic [CNT_W-1:0]    idx_plus;

   // A literal's variable index is legal when it is non-zero and within both limits.
   function automatic logic var_ok(input logic [VAR_W-1:0] v, input logic [VAR_W-1:0] count);
      return (v != '0) && (v <= VAR_W'(VARS_MAX)) && (v <= count);
   endfunction

   // Compare and swap so that the lower variable index comes first.
   function automatic logic [2*$bits(lit_type)-1:0] order_pair(input lit_type lo,
                                                                input lit_type hi);
      if (lo.idx > hi.idx) begin
         return {hi, lo};
      end
      return {lo, hi};
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff   <= VAR_W'(VARS_MAX);
         range_start_ff <= '0;
         range_end_ff   <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VAR_COUNT:   var_count_ff   <= csr_data[VAR_W-1:0];
            CSR_RANGE_START: range_start_ff <= csr_data;
            CSR_RANGE_END:   range_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Sort the three literals by variable index and check that the clause may be stored.
   always_comb begin
      lit_a = '{idx: req_payload.var_a, neg: req_payload.neg_a};
      lit_b = '{idx: req_payload.var_b, neg: req_payload.neg_b};
      lit_c = '{idx: req_payload.var_c, neg: req_payload.neg_c};
      {s1_b, s1_c} = order_pair(lit_b, lit_c);
      {s2_a, s2_c} = order_pair(lit_a, s1_c);
      {s3_a, s3_b} = order_pair(s2_a, s1_b);
      adj_a = s3_a.idx - VAR_W'(1);
      adj_b = s3_b.idx - VAR_W'(1);
      adj_c = s2_c.idx - VAR_W'(1);
      mem_wdata = {s2_c.neg, s3_b.neg, s3_a.neg,
                   adj_c[BITPOS_W-1:0], adj_b[BITPOS_W-1:0], adj_a[BITPOS_W-1:0]};
      load_ok = var_ok(req_payload.var_a, var_count_ff)
              && var_ok(req_payload.var_b, var_count_ff)
              && var_ok(req_payload.var_c, var_count_ff)
              && (total_ff != CNT_W'(CLAUSES_MAX));
      mem_we = cmd.accept && (req_payload.func == FUNC_LOAD) && load_ok;
   end

   // The memory reads ahead by one clause while the current clause passes.
   assign rd_addr = cmd.next_clause ? idx_ff + IDX_W'(1) : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         clause_mem[total_ff[IDX_W-1:0]] <= mem_wdata;
      end
      rd_data_ff <= clause_mem[rd_addr];
   end

   // A clause is false when the bit of every literal equals its negation flag.
   assign clause_false =
      (pos_ff[rd_data_ff[BITPOS_W-1:0]] == rd_data_ff[3*BITPOS_W])
      && (pos_ff[rd_data_ff[2*BITPOS_W-1:BITPOS_W]] == rd_data_ff[3*BITPOS_W+1])
      && (pos_ff[rd_data_ff[3*BITPOS_W-1:2*BITPOS_W]] == rd_data_ff[3*BITPOS_W+2]);

   // Skip target: clear the bits below the clause's lowest variable and add one there.
   always_comb begin
      step_mask = ASSIGN_W'(1) << rd_data_ff[BITPOS_W-1:0];
      skip_base = pos_ff & ~(step_mask - ASSIGN_W'(1));
      skip_sum  = {1'b0, skip_base} + {1'b0, step_mask};
      incr_sum  = {1'b0, pos_ff} + (ASSIGN_W + 1)'(1);
      idx_plus  = CNT_W'(idx_ff) + CNT_W'(1);
   end

   // Next values of the search state and the pending result.
   always_comb begin
      total_in      = total_ff;
      pos_in        = pos_ff;
      done_in       = done_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_assign_in = res_assign_ff;

      if (cmd.accept) begin
         res_assign_in = '0;
         unique case (req_payload.func)
            FUNC_LOAD: begin
               if (load_ok) begin
                  total_in      = total_ff + CNT_W'(1);
                  res_status_in = STATUS_ACCEPTED;
               end else begin
                  res_status_in = STATUS_REJECTED;
               end
            end
            FUNC_CLEAR: begin
               total_in      = '0;
               pos_in        = range_start_ff;
               done_in       = 1'b0;
               res_status_in = STATUS_CLEARED;
            end
            FUNC_FIND: res_status_in = STATUS_EXHAUSTED;
            default:   res_status_in = STATUS_REJECTED;
         endcase
      end

      if (cmd.scan_start) begin
         idx_in = '0;
      end
      if (cmd.next_clause) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.skip) begin
         if (skip_sum[ASSIGN_W]) begin
            done_in = 1'b1;
         end else begin
            pos_in = skip_sum[ASSIGN_W-1:0];
         end
      end

      if (cmd.found) begin
         res_status_in = STATUS_SOLUTION;
         res_assign_in = pos_ff;
         if (incr_sum[ASSIGN_W]) begin
            done_in = 1'b1;
         end else begin
            pos_in = incr_sum[ASSIGN_W-1:0];
         end
      end

      if (cmd.exhaust) begin
         res_status_in = STATUS_EXHAUSTED;
         res_assign_in = '0;
      end
   end

   // Output register: loaded on send, emptied when the consumer takes the transfer.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.send) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '{status: res_status_ff, assignment: res_assign_ff};
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_assign_ff  <= res_assign_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Status towards the controller.
   always_comb begin
      dp_status.is_find      = (req_payload.func == FUNC_FIND);
      dp_status.bound_fail   = done_ff || (pos_ff > range_end_ff);
      dp_status.table_empty  = (total_ff == '0);
      dp_status.clause_false = clause_false;
      dp_status.last_clause  = (idx_plus == total_ff);
      dp_status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/tsas_ctrl.sv
// Controller state machine of the assignment search: sequences loads, searches and replies.
module tsas_ctrl
   import tsas_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dp_status.is_find ? ST_BOUND : ST_REPLY;
            end
         end
         // Range check; if it passes, answer on an empty table, else start a clause pass.
         ST_BOUND: begin
            if (dp_status.bound_fail) begin
               cmd.exhaust = 1'b1;
               state_in    = ST_REPLY;
            end else if (dp_status.table_empty) begin
               cmd.found = 1'b1;
               state_in  = ST_REPLY;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_FETCH;
            end
         end
         // Wait for the first clause to come out of the memory.
         ST_FETCH: begin
            state_in = ST_TEST;
         end
         // Test one clause a cycle; the first false clause moves the candidate on.
         ST_TEST: begin
            if (dp_status.clause_false) begin
               cmd.skip = 1'b1;
               state_in = ST_BOUND;
            end else if (dp_status.last_clause) begin
               cmd.found = 1'b1;
               state_in  = ST_REPLY;
            end else begin
               cmd.next_clause = 1'b1;
            end
         end
         ST_REPLY: begin
            if (dp_status.out_free) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/three_sat_assignment_search.sv
// Top level of the three-literal CNF assignment search block.
//
// The block keeps a table of clauses of three literals and searches for the least assignment,
// from the kept position up to range_end inclusive, that makes every clause true; each find
// answers one solution or exhaustion and, on a solution, moves past it, and a clear empties the
// table and reloads range_start. Every request gives exactly one response. A load, clear or
// unused code goes straight to ST_REPLY, which registers its response on the rsp_ port once the
// output register is free. A find runs, for every candidate, the range check in ST_BOUND, the
// first clause read in ST_FETCH and the clause tests in ST_TEST; the range check ends it when the
// range or the 64-bit space runs out, or when the table is empty and the position itself is the
// answer, and its response then goes out through ST_REPLY. So the time depends on the data: it is
// set by the clause memory, read one clause a cycle, and by the number of candidates left after
// the skips. A response held by a stall keeps the next response in ST_REPLY, and so the request
// side stalled, until it is taken. The memory needs no clearing pass. Configuration is taken at
// any time on the csr_ port and should only be written while the block is idle.
module three_sat_assignment_search
   import tsas_pkg::*;
#(
   parameter int unsigned CLAUSES_MAX = CLAUSES_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ASSIGN_W-1:0]    csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   tsas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   tsas_datapath #(
      .CLAUSES_MAX (CLAUSES_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .dp_status   (dp_status)
   );

endmodule

>>> dv/search_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the responses of the assignment search block.
package search_scoreboard_pkg;
   import tsas_pkg::*;

   class search_scoreboard;
      // Predicted copy of the block's table, search state and registers.
      lit_type             clauses [CLAUSES_MAX_DEFAULT][3];
      int unsigned         clause_total;
      logic [ASSIGN_W-1:0] position;
      bit                  walk_done;
      logic [VAR_W-1:0]    var_count;
      logic [ASSIGN_W-1:0] range_start;
      logic [ASSIGN_W-1:0] range_end;
      rsp_type             awaited [$];
      int unsigned         errors;

      function new();
         clause_total = 0;
         position     = '0;
         walk_done    = 1'b0;
         var_count    = VAR_W'(VARS_MAX);
         range_start  = '0;
         range_end    = '1;
         errors       = 0;
      endfunction

      // Register write seen on the configuration port.
      function void write_reg(csr_index_type idx, logic [ASSIGN_W-1:0] value);
         case (idx)
            CSR_VAR_COUNT: begin
               var_count = value[VAR_W-1:0];
            end
            CSR_RANGE_START: begin
               range_start = value;
            end
            CSR_RANGE_END: begin
               range_end = value;
            end
            default: begin
            end
         endcase
      endfunction

      function bit index_usable(logic [VAR_W-1:0] v);
         return v >= 1 && v <= VARS_MAX && v <= var_count;
      endfunction

      // Walks candidates from the kept position. Returns the cycles the walk is expected to
      // take; it gives up once the count passes cap. State is only updated when commit is set.
      function longint unsigned walk(bit commit, longint unsigned cap, output rsp_type answer);
         logic [ASSIGN_W-1:0] cand;
         logic [ASSIGN_W-1:0] step;
         logic [ASSIGN_W-1:0] base;
         logic [ASSIGN_W:0]   sum;
         bit                  done;
         bit                  hit;
         bit                  all_false;
         int unsigned         low;
         int unsigned         i;
         int unsigned         k;
         longint unsigned     cycles;
         cand              = position;
         done              = walk_done;
         cycles            = 2;
         low               = 0;
         answer.status     = STATUS_EXHAUSTED;
         answer.assignment = '0;
         while (!done && cand <= range_end && cycles <= cap) begin
            hit = 1'b0;
            cycles += 2;
            // Clauses are tested in load order; the first false one decides the skip.
            for (i = 0; i < clause_total && !hit; i++) begin
               cycles++;
               all_false = 1'b1;
               for (k = 0; k < 3; k++) begin
                  if (cand[clauses[i][k].idx - 1] != clauses[i][k].neg) begin
                     all_false = 1'b0;
                  end
               end
               if (all_false) begin
                  hit = 1'b1;
                  low = clauses[i][0].idx - 1;
               end
            end
            if (!hit) begin
               answer.status     = STATUS_SOLUTION;
               answer.assignment = cand;
               if (cand == '1) begin
                  done = 1'b1;
               end else begin
                  cand = cand + 1'b1;
               end
               break;
            end
            // Clear the bits below the clause's lowest variable and add one at that bit.
            step = 64'd1 << low;
            base = cand & ~(step - 1'b1);
            sum  = {1'b0, base} + {1'b0, step};
            if (sum[ASSIGN_W]) begin
               done = 1'b1;
            end else begin
               cand = sum[ASSIGN_W-1:0];
            end
         end
         if (commit) begin
            position  = cand;
            walk_done = done;
         end
         return cycles;
      endfunction

      // Works out the response to a request at its transfer and queues it.
      function void note_request(req_type req);
         rsp_type answer;
         lit_type lit [3];
         lit_type tmp;
         int unsigned k;
         answer.status     = STATUS_REJECTED;
         answer.assignment = '0;
         case (req.func)
            FUNC_LOAD: begin
               if (index_usable(req.var_a) && index_usable(req.var_b) &&
                   index_usable(req.var_c) && clause_total < CLAUSES_MAX_DEFAULT) begin
                  lit[0] = '{idx: req.var_a, neg: req.neg_a};
                  lit[1] = '{idx: req.var_b, neg: req.neg_b};
                  lit[2] = '{idx: req.var_c, neg: req.neg_c};
                  // Sort the literals so that the variable indices ascend.
                  if (lit[1].idx > lit[2].idx) begin
                     tmp = lit[1]; lit[1] = lit[2]; lit[2] = tmp;
                  end
                  if (lit[0].idx > lit[2].idx) begin
                     tmp = lit[0]; lit[0] = lit[2]; lit[2] = tmp;
                  end
                  if (lit[0].idx > lit[1].idx) begin
                     tmp = lit[0]; lit[0] = lit[1]; lit[1] = tmp;
                  end
                  for (k = 0; k < 3; k++) begin
                     clauses[clause_total][k] = lit[k];
                  end
                  clause_total++;
                  answer.status = STATUS_ACCEPTED;
               end
            end
            FUNC_FIND: begin
               void'(walk(1'b1, '1, answer));
            end
            FUNC_CLEAR: begin
               clause_total  = 0;
               position      = range_start;
               walk_done     = 1'b0;
               answer.status = STATUS_CLEARED;
            end
            default: begin
            end
         endcase
         awaited.push_back(answer);
      endfunction

      // Compares a response transfer with the oldest queued prediction.
      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected response: status %0d assignment %h",
                        got.status, got.assignment);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.assignment !== want.assignment) begin
            errors++;
            if (errors <= 10) begin
               $display("response mismatch: expected status %0d assignment %h, got status %0d assignment %h",
                        want.status, want.assignment, got.status, got.assignment);
            end
         end
      endfunction
   endclass

endpackage

>>> dv/tb.sv
// Testbench top that drives the assignment search block and checks its responses.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsas_pkg::*;
   import search_scoreboard_pkg::*;

   // Searches predicted to run longer than this are replaced by a clear.
   localparam longint unsigned FIND_BUDGET = 6000;
   localparam int unsigned     HOLD_CYCLES = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [ASSIGN_W-1:0]    csr_data = '0;

   int unsigned send_idle_pct = 34;
   int unsigned recv_idle_pct = 79;
   bit          hold_request = 1'b0;
   bit          hold_taken = 1'b0;
   int unsigned hold_left = 0;

   search_scoreboard board;

   three_sat_assignment_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // Response side: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   // Every response transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_payload);
      end
   end

   // Offers one request and waits for its transfer. Called and returns at a falling edge.
   task automatic send_request(req_type req);
      rsp_type unused;
      if (req.func == FUNC_FIND && board.walk(1'b0, FIND_BUDGET, unused) > FIND_BUDGET) begin
         req.func = FUNC_CLEAR;
      end
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= req;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(req);
      @(negedge clock);
   endtask

   // Drops the request valid and waits until every predicted response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [ASSIGN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type make_req(func_type f, logic [VAR_W-1:0] a,
                                        logic [VAR_W-1:0] b, logic [VAR_W-1:0] c,
                                        logic na, logic nb, logic nc);
      req_type req;
      req.func  = f;
      req.var_a = a;
      req.var_b = b;
      req.var_c = c;
      req.neg_a = na;
      req.neg_b = nb;
      req.neg_c = nc;
      return req;
   endfunction

   // Mostly well-formed loads and finds, with some clears, bad loads and spare codes.
   function automatic req_type random_request();
      req_type     req;
      int unsigned roll;
      int unsigned top;
      req.var_a = VAR_W'($urandom);
      req.var_b = VAR_W'($urandom);
      req.var_c = VAR_W'($urandom);
      req.neg_a = 1'($urandom);
      req.neg_b = 1'($urandom);
      req.neg_c = 1'($urandom);
      top  = (board.var_count > VARS_MAX) ? VARS_MAX : board.var_count;
      roll = $urandom_range(99, 0);
      if (roll < 55) begin
         req.func  = FUNC_LOAD;
         req.var_a = VAR_W'($urandom_range(top, 1));
         req.var_b = VAR_W'($urandom_range(top, 1));
         req.var_c = VAR_W'($urandom_range(top, 1));
      end else if (roll < 80) begin
         req.func = FUNC_FIND;
      end else if (roll < 87) begin
         req.func = FUNC_CLEAR;
      end else if (roll < 94) begin
         req.func = FUNC_LOAD;
      end else begin
         req.func = FUNC_SPARE;
      end
      return req;
   endfunction

   task automatic random_phase(int unsigned count);
      repeat (count) send_request(random_request());
      settle();
   endtask

   // Run limit.
   initial begin
      #60_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [ASSIGN_W-1:0] start_val;
      logic [VAR_W-1:0]    v;
      board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(CSR_UNUSED, {$urandom, $urandom});

      // Reset settings: empty table, bad indices, spare code, repeated and unsorted clauses.
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 1, 2, 3, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 0, 2, 3, 0, 1, 0));
      send_request(make_req(FUNC_LOAD, 65, 1, 1, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 127, 127, 127, 1, 1, 1));
      send_request(make_req(FUNC_SPARE, 127, 127, 127, 1, 1, 1));
      send_request(make_req(FUNC_LOAD, 5, 5, 2, 1, 0, 0));
      send_request(make_req(FUNC_LOAD, 3, 1, 2, 1, 0, 1));
      send_request(make_req(FUNC_LOAD, 64, 63, 62, 1, 1, 1));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      settle();

      // Near the top of the range: a skip that carries out, then a solution of all ones.
      write_csr(CSR_RANGE_START, 64'hFFFF_FFFF_FFFF_FFF0);
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 64, 63, 62, 1, 1, 1));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 1, 1, 1, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 2, 2, 2, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 3, 3, 3, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 4, 4, 4, 0, 0, 0));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      settle();

      // Fewest variables, and a start position already above the end of the range.
      write_csr(CSR_VAR_COUNT, 64'd3);
      write_csr(CSR_RANGE_START, 64'd10);
      write_csr(CSR_RANGE_END, 64'd5);
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_LOAD, 4, 1, 2, 0, 0, 0));
      settle();

      // Random traffic over the whole range.
      write_csr(CSR_VAR_COUNT, 64'd64);
      write_csr(CSR_RANGE_START, 64'd0);
      write_csr(CSR_RANGE_END, '1);
      random_phase(35);

      // Random variable count over a short window; sender idles more than the receiver.
      send_idle_pct = 79;
      recv_idle_pct = 34;
      start_val = ASSIGN_W'($urandom_range(3000, 0));
      write_csr(CSR_VAR_COUNT, ASSIGN_W'($urandom_range(64, 3)));
      write_csr(CSR_RANGE_START, start_val);
      write_csr(CSR_RANGE_END, start_val + ASSIGN_W'($urandom_range(1500, 0)));
      random_phase(35);

      // Three variables, window anywhere in the 64-bit space, no idling.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      start_val = {$urandom, $urandom};
      write_csr(CSR_VAR_COUNT, 64'd3);
      write_csr(CSR_RANGE_START, start_val);
      if (start_val > 64'hFFFF_FFFF_FFFF_F000) begin
         write_csr(CSR_RANGE_END, '1);
      end else begin
         write_csr(CSR_RANGE_END, start_val + ASSIGN_W'($urandom_range(500, 0)));
      end
      random_phase(35);

      // Load clauses that are never false while the receiver holds off, so the input stalls.
      write_csr(CSR_VAR_COUNT, 64'd64);
      write_csr(CSR_RANGE_START, {$urandom, $urandom});
      write_csr(CSR_RANGE_END, '1);
      hold_request = 1'b1;
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      repeat (8) begin
         v = VAR_W'($urandom_range(64, 1));
         send_request(make_req(FUNC_LOAD, v, VAR_W'($urandom_range(64, 1)), v,
                               1'b0, 1'($urandom), 1'b1));
      end
      send_request(make_req(FUNC_FIND, 0, 0, 0, 0, 0, 0));
      send_request(make_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
      settle();

      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
